// ----- rtl/lsu_pkg.sv -----
// Shared types and constants for the lattice SIR update engine.
// Used by the lattice RAM, the update logic and the top level.
package lsu_pkg;

   localparam int ROW_W    = 8;
   localparam int ADDR_W   = 2 * ROW_W;
   localparam int NCELLS   = 1 << ADDR_W;
   localparam int CNT_W    = ADDR_W + 1;
   localparam int PROB_W   = 17;
   localparam int ACTION_W = 16;
   localparam int CELL_W   = 2;

   localparam logic [PROB_W-1:0] PROB_RESET  = PROB_W'(55706);
   localparam logic [CNT_W-1:0]  CNT_ALL     = CNT_W'(NCELLS);

   typedef logic [CELL_W-1:0] cell_type;
   typedef logic [ADDR_W-1:0] addr_type;

   localparam cell_type CELL_SUS = 2'd0;
   localparam cell_type CELL_INF = 2'd1;
   localparam cell_type CELL_REC = 2'd2;
   localparam cell_type CELL_VAX = 2'd3;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;

   localparam logic [1:0] DIR_ROW_INC = 2'd0;
   localparam logic [1:0] DIR_ROW_DEC = 2'd1;
   localparam logic [1:0] DIR_COL_INC = 2'd2;
   localparam logic [1:0] DIR_COL_DEC = 2'd3;

   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      cell_type old_cell;
      cell_type new_cell;
   } upd_type;

endpackage

// ----- rtl/lsu_lattice_ram.sv -----
// Lattice cell memory: one write port and two registered read ports.
// Depends on lsu_pkg for the address and cell types.
module lsu_lattice_ram
   import lsu_pkg::*;
(
   input  logic     clock,
   input  logic     wr_en,
   input  addr_type wr_addr,
   input  cell_type wr_data,
   input  logic     rd_en,
   input  addr_type rd_a_addr,
   input  addr_type rd_b_addr,
   output cell_type rd_a_data,
   output cell_type rd_b_data
);

   cell_type mem [NCELLS];
   cell_type rd_a_ff;
   cell_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_a_addr];
         rd_b_ff <= mem[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// ----- rtl/lsu_update_logic.sv -----
// Decides the cell write-back for one word from the cells read out of the lattice.
// Depends on lsu_pkg for cell codes and the update struct.
module lsu_update_logic
   import lsu_pkg::*;
(
   input  logic                kind,
   input  addr_type            act_addr,
   input  addr_type            nb_addr,
   input  logic [ACTION_W-1:0] action,
   input  cell_type            cell_value,
   input  logic [PROB_W-1:0]   infection_prob,
   input  cell_type            act_cell,
   input  cell_type            nb_cell,
   output upd_type             upd
);

   logic infect_branch;

   assign infect_branch = {1'b0, action} < infection_prob;

   always_comb begin
      upd.wr_en    = 1'b0;
      upd.wr_addr  = act_addr;
      upd.old_cell = act_cell;
      upd.new_cell = act_cell;
      if (kind == KIND_WRITE) begin
         upd.wr_en    = (act_cell != cell_value);
         upd.new_cell = cell_value;
      end else if (infect_branch) begin
         if ((nb_cell == CELL_SUS) && (act_cell == CELL_INF)) begin
            upd.wr_en    = 1'b1;
            upd.wr_addr  = nb_addr;
            upd.old_cell = CELL_SUS;
            upd.new_cell = CELL_INF;
         end
      end else if (act_cell == CELL_INF) begin
         upd.wr_en    = 1'b1;
         upd.new_cell = CELL_REC;
      end
   end

endmodule

// ----- rtl/lattice_sir_update_engine.sv -----
// Lattice SIR update engine: every word is accepted, read, decided and written back. At the
// accepting edge the RAM reads both cells and the engine enters EXEC; as it leaves EXEC the
// write-back is done and the result strobe rises as busy drops. Busy holds off a new word till
// then. After reset a clearing pass writes all 65536 cells susceptible, one per cycle, with busy
// high throughout; csr writes are taken during it. Results cannot be stalled.
module lattice_sir_update_engine
   import lsu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_kind,
   input  logic [ROW_W-1:0]    req_row,
   input  logic [ROW_W-1:0]    req_col,
   input  logic [1:0]          req_direction,
   input  logic [ACTION_W-1:0] req_action,
   input  cell_type            req_cell_value,
   output logic                rsp_valid,
   output logic [CNT_W-1:0]    rsp_susceptible_count,
   output logic [CNT_W-1:0]    rsp_infected_count,
   output logic [CNT_W-1:0]    rsp_recovered_count,
   output logic [CNT_W-1:0]    rsp_vaccinated_count,
   output logic                rsp_changed,
   input  logic                csr_wr_en,
   input  logic [PROB_W-1:0]   csr_wr_data
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0]          state_ff, state_in;
   addr_type            clr_ff, clr_in;
   logic [PROB_W-1:0]   prob_ff;
   logic                kind_ff;
   addr_type            act_ff, nb_ff;
   logic [ACTION_W-1:0] action_ff;
   cell_type            value_ff;
   logic [CNT_W-1:0]    count_ff [4];
   logic [CNT_W-1:0]    count_in [4];
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_changed_ff, rsp_changed_in;

   logic                accept;
   logic [ROW_W-1:0]    nb_row, nb_col;
   addr_type            req_act_addr, req_nb_addr;
   cell_type            act_cell, nb_cell;
   upd_type             upd;
   logic                ram_wr_en;
   addr_type            ram_wr_addr;
   cell_type            ram_wr_data;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      nb_row = req_row;
      nb_col = req_col;
      unique case (req_direction)
         DIR_ROW_INC: nb_row = req_row + ROW_W'(1);
         DIR_ROW_DEC: nb_row = req_row - ROW_W'(1);
         DIR_COL_INC: nb_col = req_col + ROW_W'(1);
         DIR_COL_DEC: nb_col = req_col - ROW_W'(1);
         default:     nb_row = req_row;
      endcase
   end

   assign req_act_addr = {req_row, req_col};
   assign req_nb_addr  = {nb_row, nb_col};

   lsu_update_logic u_update (
      .kind           (kind_ff),
      .act_addr       (act_ff),
      .nb_addr        (nb_ff),
      .action         (action_ff),
      .cell_value     (value_ff),
      .infection_prob (prob_ff),
      .act_cell       (act_cell),
      .nb_cell        (nb_cell),
      .upd            (upd)
   );

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = upd.wr_addr;
      ram_wr_data = upd.new_cell;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = CELL_SUS;
      end else if (state_ff == ST_EXEC) begin
         ram_wr_en = upd.wr_en;
      end
   end

   lsu_lattice_ram u_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_en     (accept),
      .rd_a_addr (req_act_addr),
      .rd_b_addr (req_nb_addr),
      .rd_a_data (act_cell),
      .rd_b_data (nb_cell)
   );

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      rsp_valid_in   = 1'b0;
      rsp_changed_in = 1'b0;
      for (int i = 0; i < 4; i++) begin
         count_in[i] = count_ff[i];
      end
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == {ADDR_W{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in       = ST_IDLE;
            rsp_valid_in   = 1'b1;
            rsp_changed_in = upd.wr_en;
            if (upd.wr_en) begin
               for (int i = 0; i < 4; i++) begin
                  if (upd.old_cell == cell_type'(i)) begin
                     count_in[i] = count_ff[i] - CNT_W'(1);
                  end else if (upd.new_cell == cell_type'(i)) begin
                     count_in[i] = count_ff[i] + CNT_W'(1);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         prob_ff        <= PROB_RESET;
         rsp_valid_ff   <= 1'b0;
         rsp_changed_ff <= 1'b0;
         count_ff[0]    <= CNT_ALL;
         count_ff[1]    <= '0;
         count_ff[2]    <= '0;
         count_ff[3]    <= '0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_changed_ff <= rsp_changed_in;
         for (int i = 0; i < 4; i++) begin
            count_ff[i] <= count_in[i];
         end
         if (csr_wr_en) begin
            prob_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_kind;
         act_ff    <= req_act_addr;
         nb_ff     <= req_nb_addr;
         action_ff <= req_action;
         value_ff  <= req_cell_value;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_changed           = rsp_changed_ff;
   assign rsp_susceptible_count = count_ff[CELL_SUS];
   assign rsp_infected_count    = count_ff[CELL_INF];
   assign rsp_recovered_count   = count_ff[CELL_REC];
   assign rsp_vaccinated_count  = count_ff[CELL_VAX];

   // The four counts always cover the whole lattice.
   assert property (@(posedge clock) disable iff (reset)
      ((CNT_W + 2)'(count_ff[0]) + (CNT_W + 2)'(count_ff[1]) + (CNT_W + 2)'(count_ff[2])
       + (CNT_W + 2)'(count_ff[3])) == (CNT_W + 2)'(NCELLS))
      else $error("state counts do not sum to the lattice size");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy && rsp_valid == 1'b0) ##1 (rsp_valid && !busy))
      else $error("result word not delivered two cycles after acceptance");

   assert property (@(posedge clock) disable iff (reset)
      rsp_changed |-> rsp_valid)
      else $error("changed flag raised outside a result word");

   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_EXEC))
      else $error("lattice written while idle");

endmodule
